[hdl/c8_pkg.sv]
// Shared types, constants and helper functions of the CHIP-8 processor core.
package c8_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int ADDR_W = $clog2(MEMORY_BYTES);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] ADDR_MAX  = 12'hFFF;
  localparam int          FONT_LEN  = 80;

  localparam logic [7:0] GLYPHS [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EXEC  = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_BAD_OP    = 2'd1,
    FAULT_OVERFLOW  = 2'd2,
    FAULT_UNDERFLOW = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    SEQ_SIMPLE,
    SEQ_CLS,
    SEQ_DRAW,
    SEQ_BCD,
    SEQ_STORE,
    SEQ_LOADR,
    SEQ_VF
  } seq_t;

  typedef enum logic [4:0] {
    ST_NONE,
    ST_CLEAR,
    ST_LOAD,
    ST_PIX_RD,
    ST_PIX_CAP,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_F5,
    ST_F6,
    ST_EXEC,
    ST_CLS,
    ST_DRAW_RD,
    ST_DRAW_ROW,
    ST_DRAW_WR,
    ST_DRAW_VF,
    ST_BCD,
    ST_STORE,
    ST_LDREG,
    ST_VF,
    ST_FIN,
    ST_OUT
  } step_t;

  typedef struct packed {
    step_t       step;
    logic        take;
    logic [11:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [15:0] opcode;
  } stat_t;

  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [11:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && a < FONT_BASE + 12'(FONT_LEN)) begin
      return GLYPHS[off[6:0]];
    end
    return 8'h00;
  endfunction

  function automatic seq_t seq_of(input logic [15:0] w);
    seq_t s;
    s = SEQ_SIMPLE;
    unique case (w[15:12])
      4'h0: if (w == 16'h00E0) s = SEQ_CLS;
      4'h8: if (w[3:0] == 4'h4 || w[3:0] == 4'h5 || w[3:0] == 4'h6 ||
                w[3:0] == 4'h7 || w[3:0] == 4'hE) s = SEQ_VF;
      4'hD: s = SEQ_DRAW;
      4'hF: begin
        if (w[7:0] == 8'h1E) s = SEQ_VF;
        else if (w[7:0] == 8'h33) s = SEQ_BCD;
        else if (w[7:0] == 8'h55) s = SEQ_STORE;
        else if (w[7:0] == 8'h65) s = SEQ_LOADR;
      end
      default: s = SEQ_SIMPLE;
    endcase
    return s;
  endfunction

endpackage

[hdl/chip8_cpu_step.sv]
// CHIP-8 processor core, top level.
// Reset sweeps all addresses (font load, screen and V clear); no input is taken before it ends.
// Load writes memory; pixel read reads the screen row and captures the bit; a spare op goes
// straight to output. Execute fetches opcode and operands, executes, then may add a VF write,
// a screen clear, read, XOR and write per sprite row plus VF write for a draw, BCD writes or
// register store and load. One transaction in flight; next input is taken once output is loaded.
module chip8_cpu_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  logic [7:0]  in_random_byte,
  input  logic [5:0]  in_pixel_x,
  input  logic [4:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_executed_opcode,
  output logic        out_pixel_value,
  output logic        out_screen_changed,
  output logic        out_sound_on,
  output logic [1:0]  out_fault
);
  import c8_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  c8_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  c8_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_operation(in_operation), .in_load_address(in_load_address),
    .in_load_data(in_load_data), .in_random_byte(in_random_byte),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_program_counter(out_program_counter),
    .out_executed_opcode(out_executed_opcode),
    .out_pixel_value(out_pixel_value),
    .out_screen_changed(out_screen_changed),
    .out_sound_on(out_sound_on),
    .out_fault(out_fault)
  );

endmodule

[hdl/c8_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/c8_datapath.sv]
// Datapath: architectural registers, memories, ALU and result register.
module c8_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  c8_pkg::cmd_t                cmd,
  output c8_pkg::stat_t               stat,
  input  logic [1:0]                  in_operation,
  input  logic [11:0]                 in_load_address,
  input  logic [7:0]                  in_load_data,
  input  logic [7:0]                  in_random_byte,
  input  logic [5:0]                  in_pixel_x,
  input  logic [4:0]                  in_pixel_y,
  output logic [11:0]                 out_program_counter,
  output logic [15:0]                 out_executed_opcode,
  output logic                        out_pixel_value,
  output logic                        out_screen_changed,
  output logic                        out_sound_on,
  output logic [1:0]                  out_fault
);
  import c8_pkg::*;

  logic [1:0]  op_r;
  logic [11:0] ld_addr_r;
  logic [7:0]  ld_data_r, rnd_r;
  logic [COL_W-1:0] px_r;
  logic [ROW_W-1:0] py_r;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [7:0]  vx_r, vx_nxt, vy_r, vy_nxt, v0_r, v0_nxt;
  logic [11:0] ret_r, ret_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [SPW-1:0] sp_r, sp_nxt, sp_dec;
  logic [7:0]  dt_r, dt_nxt, st_r, st_nxt;
  logic        hit_r, hit_nxt, flag_r, flag_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [1:0]  fault_r, fault_nxt;
  logic        drawn_r, drawn_nxt, pix_r, pix_nxt;

  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic        scr_we;
  logic [ROW_W-1:0] scr_waddr, scr_raddr;
  logic [SCREEN_WIDTH-1:0] scr_wdata, scr_rdata;
  logic        v_we;
  logic [3:0]  v_waddr, v_raddr;
  logic [7:0]  v_wdata, v_rdata;
  logic        stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [11:0] stk_wdata, stk_rdata;

  logic [3:0]  xf, yf, nf;
  logic [7:0]  nnf;
  logic [11:0] nnnf, pc2, pc4;
  logic [8:0]  sum9;
  logic [15:0] isum;
  logic [SCREEN_WIDTH-1:0] mask;
  logic [ROW_W-1:0] row_y;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_r, bcd_u;
  logic [15:0] bcd_p;
  logic [3:0]  bcd_t;
  logic [11:0] cnt_m1;

  assign xf     = opcode_r[11:8];
  assign yf     = opcode_r[7:4];
  assign nf     = opcode_r[3:0];
  assign nnf    = opcode_r[7:0];
  assign nnnf   = opcode_r[11:0];
  assign pc2    = pc_r + 12'd2;
  assign pc4    = pc_r + 12'd4;
  assign sum9   = {1'b0, vx_r} + {1'b0, vy_r};
  assign isum   = i_r + {8'h00, vx_r};
  assign sp_dec = sp_r - SPW'(1);
  assign row_y  = vy_r[ROW_W-1:0] + cmd.cnt[ROW_W-1:0];
  assign cnt_m1 = cmd.cnt - 12'd1;
  assign stat.opcode = opcode_r;

  assign bcd_h = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_r = vx_r - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
  assign bcd_p = {8'h00, bcd_r} * 16'd205;
  assign bcd_t = bcd_p[14:11];
  assign bcd_u = bcd_r - {1'b0, bcd_t, 3'b000} - {3'b000, bcd_t, 1'b0};

  always_comb begin
    logic [COL_W-1:0] col;
    mask = '0;
    for (int k = 0; k < 8; k++) begin
      col = vx_r[COL_W-1:0] + COL_W'(k);
      mask[col] = row_r[7-k];
    end
  end

  always_comb begin
    hi_nxt = hi_r;       opcode_nxt = opcode_r;
    vx_nxt = vx_r;       vy_nxt = vy_r;      v0_nxt = v0_r;
    ret_nxt = ret_r;     pc_nxt = pc_r;      i_nxt = i_r;
    sp_nxt = sp_r;       dt_nxt = dt_r;      st_nxt = st_r;
    hit_nxt = hit_r;     flag_nxt = flag_r;  row_nxt = row_r;
    fault_nxt = fault_r; drawn_nxt = drawn_r; pix_nxt = pix_r;
    mem_we = 1'b0;  mem_waddr = ld_addr_r; mem_wdata = ld_data_r; mem_raddr = pc_r;
    scr_we = 1'b0;  scr_waddr = row_y;     scr_wdata = '0;        scr_raddr = py_r;
    v_we = 1'b0;    v_waddr = xf;          v_wdata = 8'h00;       v_raddr = xf;
    stk_we = 1'b0;  stk_waddr = sp_r[SAW-1:0]; stk_wdata = pc_r;
    stk_raddr = sp_dec[SAW-1:0];

    if (cmd.take) begin
      fault_nxt = FAULT_NONE;
      drawn_nxt = 1'b0;
      pix_nxt   = 1'b0;
    end

    unique case (cmd.step)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd.cnt;
        mem_wdata = font_byte(cmd.cnt);
        scr_we    = (cmd.cnt < 12'(SCREEN_HEIGHT));
        scr_waddr = cmd.cnt[ROW_W-1:0];
        v_we      = (cmd.cnt < 12'd16);
        v_waddr   = cmd.cnt[3:0];
      end
      ST_LOAD: mem_we = 1'b1;
      ST_PIX_RD: scr_raddr = py_r;
      ST_PIX_CAP: pix_nxt = scr_rdata[px_r];
      ST_F1: mem_raddr = pc_r;
      ST_F2: begin
        hi_nxt    = mem_rdata;
        mem_raddr = pc_r + 12'd1;
      end
      ST_F3: begin
        opcode_nxt = {hi_r, mem_rdata};
        v_raddr    = hi_r[3:0];
      end
      ST_F4: begin
        vx_nxt  = v_rdata;
        v_raddr = yf;
      end
      ST_F5: begin
        vy_nxt  = v_rdata;
        ret_nxt = stk_rdata;
        v_raddr = 4'h0;
      end
      ST_F6: v0_nxt = v_rdata;
      ST_EXEC: begin
        pc_nxt = pc2;
        unique case (opcode_r[15:12])
          4'h0: begin
            if (opcode_r == 16'h00E0) begin
              drawn_nxt = 1'b1;
            end else if (opcode_r == 16'h00EE) begin
              if (sp_r != '0) begin
                sp_nxt = sp_dec;
                pc_nxt = ret_r + 12'd2;
              end else begin
                fault_nxt = FAULT_UNDERFLOW;
              end
            end else if (xf == 4'h0) begin
              fault_nxt = FAULT_BAD_OP;
            end
          end
          4'h1: pc_nxt = nnnf;
          4'h2: begin
            if (sp_r < SPW'(STACK_DEPTH)) begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SPW'(1);
              pc_nxt = nnnf;
            end else begin
              fault_nxt = FAULT_OVERFLOW;
            end
          end
          4'h3: if (vx_r == nnf) pc_nxt = pc4;
          4'h4: if (vx_r != nnf) pc_nxt = pc4;
          4'h5: begin
            if (nf != 4'h0) fault_nxt = FAULT_BAD_OP;
            else if (vx_r == vy_r) pc_nxt = pc4;
          end
          4'h6: begin
            v_we = 1'b1;  v_wdata = nnf;
          end
          4'h7: begin
            v_we = 1'b1;  v_wdata = vx_r + nnf;
          end
          4'h8: begin
            v_we = 1'b1;
            unique case (nf)
              4'h0: v_wdata = vy_r;
              4'h1: v_wdata = vx_r | vy_r;
              4'h2: v_wdata = vx_r & vy_r;
              4'h3: v_wdata = vx_r ^ vy_r;
              4'h4: begin
                v_wdata = sum9[7:0];  flag_nxt = sum9[8];
              end
              4'h5: begin
                v_wdata = vx_r - vy_r;  flag_nxt = (vx_r >= vy_r);
              end
              4'h6: begin
                v_wdata = {1'b0, vx_r[7:1]};  flag_nxt = vx_r[0];
              end
              4'h7: begin
                v_wdata = vy_r - vx_r;  flag_nxt = (vy_r >= vx_r);
              end
              4'hE: begin
                v_wdata = {vx_r[6:0], 1'b0};  flag_nxt = vx_r[7];
              end
              default: begin
                v_we = 1'b0;  fault_nxt = FAULT_BAD_OP;
              end
            endcase
          end
          4'h9: begin
            if (nf != 4'h0) fault_nxt = FAULT_BAD_OP;
            else if (vx_r != vy_r) pc_nxt = pc4;
          end
          4'hA: i_nxt = {4'h0, nnnf};
          4'hB: pc_nxt = nnnf + {4'h0, v0_r};
          4'hC: begin
            v_we = 1'b1;  v_wdata = rnd_r & nnf;
          end
          4'hD: begin
            drawn_nxt = 1'b1;  hit_nxt = 1'b0;
          end
          4'hE: ;
          4'hF: begin
            unique case (nnf)
              8'h07: begin
                v_we = 1'b1;  v_wdata = dt_r;
              end
              8'h0A: ;
              8'h15: dt_nxt = vx_r;
              8'h18: st_nxt = vx_r;
              8'h1E: begin
                i_nxt = isum;  flag_nxt = (isum > {4'h0, ADDR_MAX});
              end
              8'h29: i_nxt = {4'h0, FONT_BASE} + {6'h00, vx_r, 2'b00} + {8'h00, vx_r};
              8'h33, 8'h55, 8'h65: ;
              default: fault_nxt = FAULT_BAD_OP;
            endcase
          end
          default: ;
        endcase
      end
      ST_VF: begin
        v_we = 1'b1;  v_waddr = 4'hF;  v_wdata = {7'h00, flag_r};
      end
      ST_CLS: begin
        scr_we = 1'b1;  scr_waddr = cmd.cnt[ROW_W-1:0];
      end
      ST_DRAW_RD: mem_raddr = i_r[11:0] + cmd.cnt;
      ST_DRAW_ROW: begin
        row_nxt   = mem_rdata;
        scr_raddr = row_y;
      end
      ST_DRAW_WR: begin
        scr_we    = 1'b1;
        scr_wdata = scr_rdata ^ mask;
        hit_nxt   = hit_r | (|(scr_rdata & mask));
      end
      ST_DRAW_VF: begin
        v_we = 1'b1;  v_waddr = 4'hF;  v_wdata = {7'h00, hit_r};
      end
      ST_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[11:0] + cmd.cnt;
        unique case (cmd.cnt[1:0])
          2'd0:    mem_wdata = {6'h00, bcd_h};
          2'd1:    mem_wdata = {4'h0, bcd_t};
          default: mem_wdata = bcd_u;
        endcase
      end
      ST_STORE: begin
        v_raddr   = cmd.cnt[3:0];
        mem_we    = (cmd.cnt != 12'd0);
        mem_waddr = i_r[11:0] + cnt_m1;
        mem_wdata = v_rdata;
      end
      ST_LDREG: begin
        mem_raddr = i_r[11:0] + cmd.cnt;
        v_we      = (cmd.cnt != 12'd0);
        v_waddr   = cnt_m1[3:0];
        v_wdata   = mem_rdata;
      end
      ST_FIN: begin
        if (dt_r != 8'h00) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'h00) st_nxt = st_r - 8'd1;
      end
      ST_OUT, ST_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= START_PC;
      i_r     <= '0;
      sp_r    <= '0;
      dt_r    <= '0;
      st_r    <= '0;
      fault_r <= FAULT_NONE;
      drawn_r <= 1'b0;
      pix_r   <= 1'b0;
      op_r    <= '0;
    end else begin
      pc_r    <= pc_nxt;
      i_r     <= i_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      fault_r <= fault_nxt;
      drawn_r <= drawn_nxt;
      pix_r   <= pix_nxt;
      if (cmd.take) op_r <= in_operation;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ld_addr_r <= in_load_address;
      ld_data_r <= in_load_data;
      rnd_r     <= in_random_byte;
      px_r      <= in_pixel_x;
      py_r      <= in_pixel_y;
    end
    hi_r     <= hi_nxt;
    opcode_r <= opcode_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    v0_r     <= v0_nxt;
    ret_r    <= ret_nxt;
    hit_r    <= hit_nxt;
    flag_r   <= flag_nxt;
    row_r    <= row_nxt;
    if (cmd.step == ST_OUT) begin
      out_program_counter <= pc_r;
      out_executed_opcode <= (op_r == OP_EXEC) ? opcode_r : 16'h0000;
      out_pixel_value     <= pix_r;
      out_screen_changed  <= drawn_r;
      out_sound_on        <= (st_r != 8'h00);
      out_fault           <= fault_r;
    end
  end

  c8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_scr (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

endmodule

[hdl/c8_ctrl.sv]
// Controller: sequencer state machine and channel handshakes.
module c8_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_operation,
  output logic          out_valid,
  input  logic          out_ready,
  output c8_pkg::cmd_t  cmd,
  input  c8_pkg::stat_t stat
);
  import c8_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LOAD, S_PRD, S_PCAP,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_EXEC,
    S_CLS, S_DRD, S_DROW, S_DWR, S_DVF,
    S_BCD, S_STORE, S_LDREG, S_VF, S_FIN, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        take, emit;
  logic [11:0] last_reg;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign emit      = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign last_reg  = {8'h00, stat.opcode[11:8]} + 12'd1;

  always_comb begin
    cmd.take = take;
    cmd.cnt  = cnt_r;
    unique case (state_r)
      S_INIT:  cmd.step = ST_CLEAR;
      S_IDLE:  cmd.step = ST_NONE;
      S_LOAD:  cmd.step = ST_LOAD;
      S_PRD:   cmd.step = ST_PIX_RD;
      S_PCAP:  cmd.step = ST_PIX_CAP;
      S_F1:    cmd.step = ST_F1;
      S_F2:    cmd.step = ST_F2;
      S_F3:    cmd.step = ST_F3;
      S_F4:    cmd.step = ST_F4;
      S_F5:    cmd.step = ST_F5;
      S_F6:    cmd.step = ST_F6;
      S_EXEC:  cmd.step = ST_EXEC;
      S_CLS:   cmd.step = ST_CLS;
      S_DRD:   cmd.step = ST_DRAW_RD;
      S_DROW:  cmd.step = ST_DRAW_ROW;
      S_DWR:   cmd.step = ST_DRAW_WR;
      S_DVF:   cmd.step = ST_DRAW_VF;
      S_BCD:   cmd.step = ST_BCD;
      S_STORE: cmd.step = ST_STORE;
      S_LDREG: cmd.step = ST_LDREG;
      S_VF:    cmd.step = ST_VF;
      S_FIN:   cmd.step = ST_FIN;
      S_OUT:   cmd.step = emit ? ST_OUT : ST_NONE;
      default: cmd.step = ST_NONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == ADDR_MAX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt = 12'd0;
        if (take) begin
          unique case (in_operation)
            OP_LOAD:  state_nxt = S_LOAD;
            OP_EXEC:  state_nxt = S_F1;
            OP_PIXEL: state_nxt = S_PRD;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_LOAD: state_nxt = S_OUT;
      S_PRD:  state_nxt = S_PCAP;
      S_PCAP: state_nxt = S_OUT;
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_F3;
      S_F3:   state_nxt = S_F4;
      S_F4:   state_nxt = S_F5;
      S_F5:   state_nxt = S_F6;
      S_F6:   state_nxt = S_EXEC;
      S_EXEC: begin
        cnt_nxt = 12'd0;
        unique case (seq_of(stat.opcode))
          SEQ_CLS:   state_nxt = S_CLS;
          SEQ_DRAW:  state_nxt = (stat.opcode[3:0] == 4'h0) ? S_DVF : S_DRD;
          SEQ_BCD:   state_nxt = S_BCD;
          SEQ_STORE: state_nxt = S_STORE;
          SEQ_LOADR: state_nxt = S_LDREG;
          SEQ_VF:    state_nxt = S_VF;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_CLS: begin
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'(SCREEN_HEIGHT - 1)) state_nxt = S_FIN;
      end
      S_DRD:  state_nxt = S_DROW;
      S_DROW: state_nxt = S_DWR;
      S_DWR: begin
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == {8'h00, stat.opcode[3:0]} - 12'd1) state_nxt = S_DVF;
        else state_nxt = S_DRD;
      end
      S_DVF: state_nxt = S_FIN;
      S_BCD: begin
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'd2) state_nxt = S_FIN;
      end
      S_STORE, S_LDREG: begin
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == last_reg) state_nxt = S_FIN;
      end
      S_VF:  state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ready)
    else $error("ready still high after a transaction was taken");
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (!in_ready && !out_valid_r))
    else $error("handshake active during clearing pass");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("result loaded without valid");
`endif

endmodule
